### design/frq_pkg.sv
// Shared types and constants for the FIFO run queue scheduler.
`default_nettype none

package frq_pkg;

  // Fixed field widths
  localparam int ACT_W   = 2;
  localparam int PID_W   = 5;
  localparam int SLICE_W = 15;
  localparam int MAX_W   = 8;
  localparam int CNT_W   = 6;

  // Configuration port
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;

  // Defaults for top-level parameters
  localparam int NUM_PROCS_DEF    = 32;
  localparam int SLICE_FACTOR_DEF = 100;

  // Reset value of max_slice and the largest slice that fits
  localparam logic [MAX_W-1:0]   MAX_SLICE_RST = 8'd5;
  localparam int                 SLICE_MAX     = 32767;

  // Action codes of an input beat
  typedef enum logic [ACT_W-1:0] {
    ACT_ENQ  = 2'd0,
    ACT_DEQ  = 2'd1,
    ACT_PICK = 2'd2,
    ACT_TICK = 2'd3
  } action_t;

  // Register index (word address bit above the byte offset)
  typedef enum logic {
    REG_MAX_SLICE = 1'b0,
    REG_NONE      = 1'b1
  } reg_idx_t;

  // Update strobes broadcast to every slot cell
  typedef struct packed {
    logic op_enq;
    logic op_deq;
    logic op_tick;
    logic nxt_we;
    logic prv_we;
  } frq_ctl_t;

endpackage

`default_nettype wire

### design/fifo_run_queue_scheduler.sv
// Top level of the FIFO run queue scheduler: command decode, queue ends, slot cells.
//
// Usage:
//   Input channel: drive in_action and in_proc_id with start high; the beat is
//   taken at a rising edge where start is high and busy is low. busy stays low,
//   so one beat can be issued every cycle.
//   Result channel: exactly one result beat per input beat, shown for one cycle
//   with out_valid high, in the cycle after the input beat was taken. The
//   receiver cannot stall; results are not held.
//   Throughput: one item per cycle. Each action reads the named slot's cell
//   and the head cell and updates at most three cells in the same cycle, so the
//   row of slot cells bounds the cycle time, not the item rate.
//   Configuration: APB-style port, max_slice at byte address 0. The slice
//   grant (max_slice times the slice factor, saturated) is registered when the
//   register is written.
//   Reset: rst_n low empties the queue, clears all slices and sets max_slice
//   to 5. No clearing pass is needed; the block takes beats right after reset.
`default_nettype none

module fifo_run_queue_scheduler
  import frq_pkg::*;
#(
  parameter int NUM_PROCS    = NUM_PROCS_DEF,
  parameter int SLICE_FACTOR = SLICE_FACTOR_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [ACT_W-1:0]   in_action,
  input  wire logic [PID_W-1:0]   in_proc_id,
  // result channel
  output logic                    out_valid,
  output logic                    out_picked_valid,
  output logic [PID_W-1:0]        out_picked_id,
  output logic [SLICE_W-1:0]      out_slice_left,
  output logic                    out_resched,
  output logic                    out_error,
  output logic [CNT_W-1:0]        out_queue_count,
  // configuration port
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [CFG_AW-1:0]  cfg_paddr,
  input  wire logic [CFG_DW-1:0]  cfg_pwdata,
  output logic [CFG_DW-1:0]       cfg_prdata,
  output logic                    cfg_pready
);

  localparam int IDW  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int OCW  = $clog2(NUM_PROCS + 1);
  localparam int PRW  = MAX_W + $clog2(SLICE_FACTOR + 1);
  localparam int GRANT_RST_I = int'(MAX_SLICE_RST) * SLICE_FACTOR;
  localparam logic [SLICE_W-1:0] GRANT_RST =
    SLICE_W'((GRANT_RST_I > SLICE_MAX) ? SLICE_MAX : GRANT_RST_I);
  localparam logic [PRW-1:0] SAT_P = PRW'(SLICE_MAX);

  // Configuration registers
  logic [MAX_W-1:0]   max_slice_r;
  logic [SLICE_W-1:0] grant_r;
  logic               cfg_we;
  logic [PRW-1:0]     grant_prod;
  logic [SLICE_W-1:0] grant_nxt;
  reg_idx_t           cfg_idx;

  // Queue ends and count
  logic [IDW-1:0] head_r, head_nxt;
  logic [IDW-1:0] tail_r, tail_nxt;
  logic [OCW-1:0] occ_r, occ_nxt;

  // Result registers
  logic               out_valid_r;
  logic               pv_r, pv_nxt;
  logic [PID_W-1:0]   pid_r, pid_nxt;
  logic [SLICE_W-1:0] slice_r, slice_nxt;
  logic               resched_r, resched_nxt;
  logic               err_r, err_nxt;
  logic [OCW-1:0]     cnt_r;

  // Cell row
  logic [IDW-1:0]     cell_next  [NUM_PROCS];
  logic [IDW-1:0]     cell_prev  [NUM_PROCS];
  logic               cell_inq   [NUM_PROCS];
  logic [SLICE_W-1:0] cell_slice [NUM_PROCS];

  frq_ctl_t       ctl;
  logic [IDW-1:0] nxt_slot, nxt_val, prv_slot, prv_val;

  // Decode
  logic               accept;
  action_t            act;
  logic               in_range;
  logic [IDW-1:0]     idx;
  logic               cur_inq;
  logic [SLICE_W-1:0] cur_slice;
  logic [IDW-1:0]     cur_next, cur_prev;
  logic [SLICE_W-1:0] tick_slice;
  logic               grant_due;

  assign busy       = 1'b0;
  assign accept     = start & ~busy;
  assign act        = action_t'(in_action);
  assign in_range   = (32'(in_proc_id) < 32'(NUM_PROCS));
  assign idx        = IDW'(in_proc_id);
  assign cur_inq    = cell_inq[idx];
  assign cur_slice  = cell_slice[idx];
  assign cur_next   = cell_next[idx];
  assign cur_prev   = cell_prev[idx];
  assign tick_slice = (cur_slice != '0) ? (cur_slice - SLICE_W'(1)) : cur_slice;
  assign grant_due  = (cur_slice == '0) || (cur_slice > SLICE_W'(max_slice_r));

  // APB write decode and slice grant
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready &
                      (cfg_idx == REG_MAX_SLICE);
  assign grant_prod = PRW'(cfg_pwdata[MAX_W-1:0]) * PRW'(SLICE_FACTOR);
  assign grant_nxt  = (grant_prod > SAT_P) ? SLICE_W'(SLICE_MAX)
                                           : SLICE_W'(grant_prod);
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      REG_MAX_SLICE: cfg_prdata = CFG_DW'(max_slice_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_slice_r <= MAX_SLICE_RST;
      grant_r     <= GRANT_RST;
    end else if (cfg_we) begin
      max_slice_r <= cfg_pwdata[MAX_W-1:0];
      grant_r     <= grant_nxt;
    end
  end

  // Decode the action into cell strobes, queue-end updates and the result
  always_comb begin
    ctl         = '0;
    nxt_slot    = '0;
    nxt_val     = '0;
    prv_slot    = '0;
    prv_val     = '0;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    occ_nxt     = occ_r;
    pv_nxt      = 1'b0;
    pid_nxt     = '0;
    slice_nxt   = '0;
    resched_nxt = 1'b0;
    err_nxt     = 1'b0;
    if (accept) begin
      if (act == ACT_PICK) begin
        if (occ_r != '0) begin
          pv_nxt    = 1'b1;
          pid_nxt   = PID_W'(head_r);
          slice_nxt = cell_slice[head_r];
        end
      end else if (!in_range) begin
        err_nxt = 1'b1;
      end else begin
        unique case (act)
          ACT_ENQ: begin
            slice_nxt = cur_slice;
            if (cur_inq) begin
              err_nxt = 1'b1;
            end else begin
              ctl.op_enq = 1'b1;
              if (occ_r == '0) begin
                head_nxt = idx;
              end else begin
                ctl.nxt_we = 1'b1;
                nxt_slot   = tail_r;
                nxt_val    = idx;
              end
              tail_nxt = idx;
              occ_nxt  = occ_r + OCW'(1);
              if (grant_due) begin
                slice_nxt = grant_r;
              end
            end
          end
          ACT_DEQ: begin
            slice_nxt = cur_slice;
            if (!cur_inq) begin
              err_nxt = 1'b1;
            end else begin
              ctl.op_deq = 1'b1;
              if (head_r == idx) begin
                head_nxt = cur_next;
              end else begin
                ctl.nxt_we = 1'b1;
                nxt_slot   = cur_prev;
                nxt_val    = cur_next;
              end
              if (tail_r == idx) begin
                tail_nxt = cur_prev;
              end else begin
                ctl.prv_we = 1'b1;
                prv_slot   = cur_next;
                prv_val    = cur_prev;
              end
              if (occ_r != '0) begin
                occ_nxt = occ_r - OCW'(1);
              end
            end
          end
          ACT_TICK: begin
            ctl.op_tick = 1'b1;
            slice_nxt   = tick_slice;
            resched_nxt = (tick_slice == '0);
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Queue ends and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      occ_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      occ_r  <= occ_nxt;
    end
  end

  // Result beat strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    pv_r      <= pv_nxt;
    pid_r     <= pid_nxt;
    slice_r   <= slice_nxt;
    resched_r <= resched_nxt;
    err_r     <= err_nxt;
    cnt_r     <= occ_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_picked_valid = pv_r;
  assign out_picked_id    = pid_r;
  assign out_slice_left   = slice_r;
  assign out_resched      = resched_r;
  assign out_error        = err_r;
  assign out_queue_count  = CNT_W'(cnt_r);

  // Row of slot cells
  for (genvar g = 0; g < NUM_PROCS; g++) begin : g_cell
    frq_cell #(
      .IDW  (IDW),
      .SLOT (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .cmd_id    (idx),
      .enq_prev  (tail_r),
      .nxt_slot  (nxt_slot),
      .nxt_val   (nxt_val),
      .prv_slot  (prv_slot),
      .prv_val   (prv_val),
      .max_slice (max_slice_r),
      .grant     (grant_r),
      .next_o    (cell_next[g]),
      .prev_o    (cell_prev[g]),
      .inq_o     (cell_inq[g]),
      .slice_o   (cell_slice[g])
    );
  end

endmodule

`default_nettype wire

### design/frq_cell.sv
// One slot cell: links, queued flag and time slice of a single process slot.
`default_nettype none

module frq_cell
  import frq_pkg::*;
#(
  parameter int IDW  = 5,
  parameter int SLOT = 0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire frq_ctl_t           ctl,
  input  wire logic [IDW-1:0]     cmd_id,
  input  wire logic [IDW-1:0]     enq_prev,
  input  wire logic [IDW-1:0]     nxt_slot,
  input  wire logic [IDW-1:0]     nxt_val,
  input  wire logic [IDW-1:0]     prv_slot,
  input  wire logic [IDW-1:0]     prv_val,
  input  wire logic [MAX_W-1:0]   max_slice,
  input  wire logic [SLICE_W-1:0] grant,
  output logic [IDW-1:0]          next_o,
  output logic [IDW-1:0]          prev_o,
  output logic                    inq_o,
  output logic [SLICE_W-1:0]      slice_o
);

  localparam logic [IDW-1:0] ME = IDW'(SLOT);

  logic [IDW-1:0]     next_r, next_nxt;
  logic [IDW-1:0]     prev_r, prev_nxt;
  logic               inq_r, inq_nxt;
  logic [SLICE_W-1:0] slice_r, slice_nxt;
  logic               hit;

  assign hit = (cmd_id == ME);

  // Work out this slot's next state from the broadcast command
  always_comb begin
    next_nxt  = next_r;
    prev_nxt  = prev_r;
    inq_nxt   = inq_r;
    slice_nxt = slice_r;
    if (ctl.op_enq && hit) begin
      inq_nxt  = 1'b1;
      prev_nxt = enq_prev;
      next_nxt = '0;
      if ((slice_r == '0) || (slice_r > SLICE_W'(max_slice))) begin
        slice_nxt = grant;
      end
    end
    if (ctl.op_deq && hit) begin
      inq_nxt = 1'b0;
    end
    if (ctl.op_tick && hit && (slice_r != '0)) begin
      slice_nxt = slice_r - SLICE_W'(1);
    end
    // Relink a neighbor of the slot being added or removed
    if (ctl.nxt_we && (nxt_slot == ME)) begin
      next_nxt = nxt_val;
    end
    if (ctl.prv_we && (prv_slot == ME)) begin
      prev_nxt = prv_val;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_r   <= 1'b0;
      slice_r <= '0;
    end else begin
      inq_r   <= inq_nxt;
      slice_r <= slice_nxt;
    end
  end

  // Links hold no reset value; they are written before any read
  always_ff @(posedge clk) begin
    next_r <= next_nxt;
    prev_r <= prev_nxt;
  end

  assign next_o  = next_r;
  assign prev_o  = prev_r;
  assign inq_o   = inq_r;
  assign slice_o = slice_r;

endmodule

`default_nettype wire
